// File: rtl/core/lpdg_pkg.sv
// Shared types, codes and constants of the LED pattern duty generator.
package lpdg_pkg;

  // Width of the duty result and its saturation value
  localparam int DUTY_W   = 11;
  localparam int DUTY_MAX = 2**DUTY_W - 1;

  // Configuration register widths
  localparam int LUM_W    = 9;
  localparam int STEP_W   = 7;
  localparam int STEP_MAX = 2**STEP_W - 1;

  // Default top of the pattern count
  localparam int MAX_LEVEL_DEF = 1023;

  // Stream and configuration port widths
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = LUM_W;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_ENABLE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_LUMINANCE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SOFT_STEP = 2'd2;

  typedef enum logic [1:0] {
    OP_COMPARE  = 2'd0,
    OP_TIMER    = 2'd1,
    OP_SET_MODE = 2'd2,
    OP_RESERVED = 2'd3
  } lpdg_op_t;

  typedef enum logic [1:0] {
    MODE_OFF  = 2'd0,
    MODE_SOFT = 2'd1,
    MODE_ON   = 2'd2,
    MODE_HARD = 2'd3
  } lpdg_mode_t;

  typedef struct packed {
    logic              light_en;
    logic [LUM_W-1:0]  luminance;
    logic [STEP_W-1:0] soft_step;
  } lpdg_cfg_t;

endpackage

// File: rtl/core/lpdg_pattern.sv
// Pattern stage: holds mode and level state and registers the raw pattern value.
module lpdg_pattern #(
  parameter int MAX_LEVEL = lpdg_pkg::MAX_LEVEL_DEF,
  parameter int LVL_W     = $clog2(MAX_LEVEL + lpdg_pkg::STEP_MAX + 1)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  lpdg_pkg::lpdg_cfg_t    cfg,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  lpdg_pkg::lpdg_op_t     opcode,
  input  lpdg_pkg::lpdg_mode_t   mode_value,
  output logic                   val_valid,
  input  logic                   val_ready,
  output logic [LVL_W-1:0]       value,
  output lpdg_pkg::lpdg_mode_t   mode,
  output logic [LVL_W-1:0]       level
);
  import lpdg_pkg::*;

  localparam logic [LVL_W-1:0] TOP  = LVL_W'(MAX_LEVEL);
  localparam logic [LVL_W-1:0] HALF = LVL_W'(MAX_LEVEL / 2);

  lpdg_mode_t       mode_r, mode_nxt;
  logic [LVL_W-1:0] level_r, level_nxt;
  logic             ramp_up_r, ramp_up_nxt;
  logic             val_valid_r, val_valid_nxt;
  logic [LVL_W-1:0] value_r, value_nxt;

  logic             fire;
  logic [LVL_W-1:0] step;
  logic [LVL_W-1:0] pattern;

  assign in_ready = !val_valid_r || val_ready;
  assign fire     = in_valid && in_ready;
  assign step     = LVL_W'(cfg.soft_step);

  // Next state and pattern value for one transfer from the input register.
  always_comb begin
    mode_nxt    = mode_r;
    level_nxt   = level_r;
    ramp_up_nxt = ramp_up_r;
    pattern     = '0;
    if (fire) begin
      case (opcode)
        OP_COMPARE: begin
          case (mode_r)
            MODE_SOFT: begin
              if (ramp_up_r) begin
                if (level_r < TOP) begin
                  level_nxt = level_r + step;
                end else begin
                  ramp_up_nxt = 1'b0;
                end
              end else begin
                if (level_r != '0) begin
                  level_nxt = (level_r > step) ? level_r - step : '0;
                end else begin
                  ramp_up_nxt = 1'b1;
                end
              end
              pattern = level_nxt;
            end
            MODE_ON: begin
              level_nxt = TOP + LVL_W'(1);
              pattern   = level_nxt;
            end
            MODE_HARD: begin
              // High on odd groups of sixteen counts within the first half.
              if (level_r < HALF && level_r[4]) begin
                pattern = TOP;
              end
              level_nxt = (level_r >= TOP) ? '0 : level_r + LVL_W'(1);
            end
            default: begin
              level_nxt = '0;
            end
          endcase
        end
        OP_SET_MODE: begin
          if (!cfg.light_en) begin
            mode_nxt  = MODE_OFF;
            level_nxt = '0;
          end else if (mode_value != mode_r) begin
            mode_nxt  = mode_value;
            level_nxt = '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    val_valid_nxt = val_valid_r;
    value_nxt     = value_r;
    if (fire) begin
      val_valid_nxt = opcode inside {OP_COMPARE, OP_TIMER};
      value_nxt     = pattern;
    end else if (val_ready) begin
      val_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_OFF;
      level_r     <= '0;
      ramp_up_r   <= 1'b1;
      val_valid_r <= 1'b0;
    end else begin
      mode_r      <= mode_nxt;
      level_r     <= level_nxt;
      ramp_up_r   <= ramp_up_nxt;
      val_valid_r <= val_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign val_valid = val_valid_r;
  assign value     = value_r;
  assign mode      = mode_r;
  assign level     = level_r;

endmodule

// File: rtl/core/lpdg_scale.sv
// Scale stage: luminance multiply, saturation and the result register.
module lpdg_scale #(
  parameter int MAX_LEVEL = lpdg_pkg::MAX_LEVEL_DEF,
  parameter int LVL_W     = $clog2(MAX_LEVEL + lpdg_pkg::STEP_MAX + 1)
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [lpdg_pkg::LUM_W-1:0]      luminance,
  input  logic                            val_valid,
  output logic                            val_ready,
  input  logic [LVL_W-1:0]                value,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [lpdg_pkg::DUTY_W-1:0]     duty
);
  import lpdg_pkg::*;

  localparam int PROD_W = LVL_W + LUM_W;
  localparam int SHR_W  = PROD_W - 8;
  localparam int CMP_W  = (SHR_W > DUTY_W) ? SHR_W : DUTY_W;

  logic [PROD_W-1:0] prod;
  logic [CMP_W-1:0]  scaled;
  logic [DUTY_W-1:0] duty_sat;

  logic              out_valid_r, out_valid_nxt;
  logic [DUTY_W-1:0] duty_r, duty_nxt;

  // Q1.8 scaling: drop the eight fraction bits, then clamp to the duty range.
  assign prod     = PROD_W'(value) * PROD_W'(luminance);
  assign scaled   = CMP_W'(prod[PROD_W-1:8]);
  assign duty_sat = (scaled > CMP_W'(DUTY_MAX)) ? DUTY_W'(DUTY_MAX) : DUTY_W'(scaled);

  assign val_ready = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    duty_nxt      = duty_r;
    if (val_valid && val_ready) begin
      out_valid_nxt = 1'b1;
      duty_nxt      = duty_sat;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    duty_r <= duty_nxt;
  end

  assign out_valid = out_valid_r;
  assign duty      = duty_r;

endmodule

// File: rtl/core/led_pattern_duty_generator_unit.sv
// Top level of the LED pattern duty generator: input register, config registers, stages.
//
//   Channel  Direction  Handshake               Payload
//   in_      slave      in_tvalid / in_tready   in_tdata: opcode, mode_value
//   out_     master     out_tvalid / out_tready out_tdata: duty
//   cfg_     slave      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One item can be accepted every cycle unless a low out_tready holds the stages; a duty
// result passes through the input register and the pattern register, then reaches the
// result register after the multiply.
// Reset sets the mode to off, the level to zero, the ramp direction to upward and the
// configuration registers to their defaults, and clears all valid flags.
// A low out_tready backs up through the registers one stage at a time; items that
// yield no result are dropped at the pattern stage. Configuration is always ready.
module led_pattern_duty_generator_unit #(
  parameter int MAX_LEVEL = lpdg_pkg::MAX_LEVEL_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // in_tdata: [1:0] opcode, [3:2] mode_value, [7:4] zero
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [lpdg_pkg::IN_TDATA_W-1:0]    in_tdata,
  // out_tdata: [10:0] duty, [15:11] zero
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [lpdg_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [lpdg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lpdg_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import lpdg_pkg::*;

  localparam int LVL_W = $clog2(MAX_LEVEL + STEP_MAX + 1);

  lpdg_cfg_t        cfg_r, cfg_nxt;
  logic             in_valid_r, in_valid_nxt;
  lpdg_op_t         opcode_r, opcode_nxt;
  lpdg_mode_t       mode_req_r, mode_req_nxt;

  logic             pat_ready;
  logic             val_valid;
  logic             val_ready;
  logic [LVL_W-1:0] value;
  lpdg_mode_t       mode;
  logic [LVL_W-1:0] level;
  logic [DUTY_W-1:0] duty;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_IDX_ENABLE:    cfg_nxt.light_en  = cfg_data[0];
        CFG_IDX_LUMINANCE: cfg_nxt.luminance = cfg_data[LUM_W-1:0];
        CFG_IDX_SOFT_STEP: cfg_nxt.soft_step = cfg_data[STEP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Input register; it refills in the same cycle it hands its item on.
  assign in_tready = !in_valid_r || pat_ready;

  always_comb begin
    in_valid_nxt = in_valid_r;
    opcode_nxt   = opcode_r;
    mode_req_nxt = mode_req_r;
    if (in_tvalid && in_tready) begin
      in_valid_nxt = 1'b1;
      opcode_nxt   = lpdg_op_t'(in_tdata[1:0]);
      mode_req_nxt = lpdg_mode_t'(in_tdata[3:2]);
    end else if (pat_ready) begin
      in_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.light_en  <= 1'b0;
      cfg_r.luminance <= LUM_W'(256);
      cfg_r.soft_step <= STEP_W'(1);
      in_valid_r      <= 1'b0;
    end else begin
      cfg_r      <= cfg_nxt;
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    opcode_r   <= opcode_nxt;
    mode_req_r <= mode_req_nxt;
  end

  lpdg_pattern #(
    .MAX_LEVEL (MAX_LEVEL),
    .LVL_W     (LVL_W)
  ) u_pattern (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_valid   (in_valid_r),
    .in_ready   (pat_ready),
    .opcode     (opcode_r),
    .mode_value (mode_req_r),
    .val_valid  (val_valid),
    .val_ready  (val_ready),
    .value      (value),
    .mode       (mode),
    .level      (level)
  );

  lpdg_scale #(
    .MAX_LEVEL (MAX_LEVEL),
    .LVL_W     (LVL_W)
  ) u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .luminance (cfg_r.luminance),
    .val_valid (val_valid),
    .val_ready (val_ready),
    .value     (value),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .duty      (duty)
  );

  assign out_tdata = OUT_TDATA_W'(duty);

  // The input side only stalls when the input register holds an item.
  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> in_valid_r)
    else $error("input stalled with an empty input register");

  // A fresh result always comes from a pattern value that was valid in the cycle before.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(val_valid))
    else $error("result appeared without a pattern value");

  // In off mode the level stays at zero.
  a_off_level: assert property (@(posedge clk) disable iff (!rst_n)
    mode == MODE_OFF |-> level == '0)
    else $error("level not zero in off mode");

  // The level never exceeds the top plus one soft step of overshoot.
  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    level <= LVL_W'(MAX_LEVEL + STEP_MAX - 1))
    else $error("level counter out of range");

endmodule
